/* rtl/cmnp_pkg.sv */
package cmnp_pkg;

    localparam int RAW_BITS  = 12;
    localparam int CNT_W     = $clog2(RAW_BITS);
    localparam int TICK_W    = 23;
    localparam int WHEEL_W   = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 23;

    localparam logic [TICK_W-1:0]  TICK_MAX        = '1;
    localparam logic [3:0]         MAG_RESET       = 4'd1;
    localparam logic [TICK_W-1:0]  THRESHOLD_RESET = TICK_W'(7458);
    localparam logic [WHEEL_W-1:0] WHEEL_RESET     = WHEEL_W'(2386363);

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_FRAME    = 3'd1,
        OP_RESET    = 3'd2,
        OP_READ_D   = 3'd3,
        OP_READ_B   = 3'd4,
        OP_SET_B    = 3'd5,
        OP_WHEEL    = 3'd6,
        OP_UNUSED   = 3'd7
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAG       = 3'd0,
        REG_CONNECTED = 3'd1,
        REG_SWAP_SR   = 3'd2,
        REG_SWAP_12   = 3'd3,
        REG_THRESHOLD = 3'd4,
        REG_WHEEL     = 3'd5
    } t_reg;

    typedef struct packed {
        logic       done;
        logic [7:0] delta;
    } t_lane_res;

    typedef struct packed {
        logic       valid;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_move;

endpackage

/* rtl/cmnp_in_if.sv */
interface cmnp_in_if;
    import cmnp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [2:0]                 op;
    logic signed [RAW_BITS-1:0] raw_dx;
    logic signed [RAW_BITS-1:0] raw_dy;
    logic                       wide_display;
    logic [3:0]                 host_buttons;
    logic [3:0]                 pad_buttons;
    logic                       overclocked;

    modport source (
        output valid, op, raw_dx, raw_dy, wide_display, host_buttons, pad_buttons,
               overclocked,
        input  ready
    );
    modport sink (
        input  valid, op, raw_dx, raw_dy, wide_display, host_buttons, pad_buttons,
               overclocked,
        output ready
    );
endinterface

/* rtl/cmnp_out_if.sv */
interface cmnp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/console_mouse_nibble_port_top.sv */
// result: an accepted transaction's result enters the output register in the next cycle,
// except a frame update while connected, which first goes through the divider in each axis lane
// throughput: one transaction per cycle for port and tick ops while the output is taken; a
// connected frame update holds off the input until the bit-per-step dividers have finished
// reset: synchronous, active low; restores configuration and state registers, output empty
module console_mouse_nibble_port_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cmnp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cmnp_pkg::CFG_W-1:0]        i_cfg_data,
    cmnp_in_if.sink                           i_item,
    cmnp_out_if.source                        o_result
);
    import cmnp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    t_state              r_state;
    logic [3:0]          r_mag;
    logic                r_connected, r_swap_sr, r_swap_12;
    logic [TICK_W-1:0]   r_threshold, r_tick;
    logic [WHEEL_W-1:0]  r_wheel_hold, r_wheel;
    logic [2:0]          r_read_idx;
    logic [7:0]          r_dx, r_dy;
    logic [3:0]          r_buttons;
    logic                r_wide;
    logic                r_out_valid;
    logic [3:0]          r_out_data;

    logic                accept, start, push;
    logic [3:0]          n_data, mag_eff, btn;
    t_lane_res           res_x, res_y;
    t_move               move;

    assign accept         = i_item.valid && i_item.ready;
    assign i_item.ready   = (r_state == ST_IDLE) && (!r_out_valid || o_result.ready);
    assign start          = accept && (t_op'(i_item.op) == OP_FRAME) && r_connected;
    assign mag_eff        = (r_mag == 4'd0) ? 4'd1 : r_mag;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    cmnp_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_raw   (i_item.raw_dx),
        .i_mag   (mag_eff),
        .o_res   (res_x)
    );

    cmnp_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_raw   (i_item.raw_dy),
        .i_mag   (mag_eff),
        .o_res   (res_y)
    );

    cmnp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_x     (res_x),
        .i_y     (res_y),
        .i_wide  (r_wide),
        .o_move  (move)
    );

    // button read: merge, swap, invert; delta nibble select and output push
    always_comb begin
        btn = r_buttons;
        if (btn[3:2] == 2'b11) begin
            btn[3:2] = 2'b00;
        end
        btn = btn | i_item.pad_buttons;
        if (r_swap_sr) begin
            btn = {btn[2], btn[3], btn[1:0]};
        end
        if (r_swap_12) begin
            btn = {btn[3:2], btn[0], btn[1]};
        end
        btn = ~btn;

        n_data = '0;
        case (t_op'(i_item.op))
            OP_READ_D: begin
                case (r_read_idx)
                    3'd0:    n_data = r_dx[7:4];
                    3'd1:    n_data = r_dx[3:0];
                    3'd2:    n_data = r_dy[7:4];
                    3'd3:    n_data = r_dy[3:0];
                    default: n_data = '0;
                endcase
            end
            OP_READ_B: n_data = btn;
            default:   n_data = '0;
        endcase
        push = (accept && !start) || (r_state == ST_DIV && move.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag        <= MAG_RESET;
            r_connected  <= 1'b0;
            r_swap_sr    <= 1'b0;
            r_swap_12    <= 1'b0;
            r_threshold  <= THRESHOLD_RESET;
            r_wheel_hold <= WHEEL_RESET;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_MAG:       r_mag        <= i_cfg_data[3:0];
                REG_CONNECTED: r_connected  <= i_cfg_data[0];
                REG_SWAP_SR:   r_swap_sr    <= i_cfg_data[0];
                REG_SWAP_12:   r_swap_12    <= i_cfg_data[0];
                REG_THRESHOLD: r_threshold  <= i_cfg_data[TICK_W-1:0];
                REG_WHEEL:     r_wheel_hold <= i_cfg_data[WHEEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_read_idx  <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_buttons   <= '0;
            r_tick      <= '0;
            r_wheel     <= '0;
            r_wide      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_DIV;
                        r_wide  <= i_item.wide_display;
                    end
                end
                ST_DIV: begin
                    if (move.valid) begin
                        r_state <= ST_IDLE;
                        r_dx    <= move.dx;
                        r_dy    <= move.dy;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (accept) begin
                case (t_op'(i_item.op))
                    OP_TICK: begin
                        if (r_tick != TICK_MAX) begin
                            r_tick <= r_tick + 1'b1;
                        end
                        if (r_wheel != '0 && !i_item.overclocked) begin
                            r_wheel <= r_wheel - 1'b1;
                            if (r_wheel == WHEEL_W'(1)) begin
                                r_buttons[3:2] <= 2'b00;
                            end
                        end
                    end
                    OP_RESET: begin
                        if (r_tick >= r_threshold) begin
                            r_read_idx <= '0;
                            r_tick     <= '0;
                        end
                    end
                    OP_READ_D: begin
                        if (r_read_idx inside {3'd0, 3'd1, 3'd2, 3'd3}) begin
                            r_read_idx <= r_read_idx + 1'b1;
                        end else begin
                            r_read_idx <= 3'd4;
                            r_dx       <= '0;
                            r_dy       <= '0;
                        end
                    end
                    OP_SET_B: r_buttons <= i_item.host_buttons;
                    OP_WHEEL: r_wheel   <= r_wheel_hold;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_data <= (r_state == ST_DIV) ? 4'd0 : n_data;
        end
    end

endmodule

/* rtl/cmnp_lane.sv */
module cmnp_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [cmnp_pkg::RAW_BITS-1:0] i_raw,
    input  logic [3:0]                           i_mag,
    output cmnp_pkg::t_lane_res                  o_res
);
    import cmnp_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(RAW_BITS - 1);

    logic                r_busy, r_done, r_neg;
    logic [CNT_W-1:0]    r_cnt;
    logic [RAW_BITS-1:0] r_num, r_quo;
    logic [3:0]          r_rem;

    logic [4:0]          trial, diff;
    logic                fits;
    logic [RAW_BITS-1:0] mag_abs, n_num;
    logic [7:0]          q8, mag8;

    // one quotient bit per step, ceiling via bias of divisor minus one
    always_comb begin
        trial   = {r_rem, r_num[RAW_BITS-1]};
        diff    = trial - {1'b0, i_mag};
        fits    = trial >= {1'b0, i_mag};
        mag_abs = i_raw[RAW_BITS-1] ? RAW_BITS'(~i_raw + 1'b1) : RAW_BITS'(i_raw);
        n_num   = mag_abs + RAW_BITS'(i_mag) - RAW_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= n_num;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_raw[RAW_BITS-1];
        end else if (r_busy) begin
            r_num <= {r_num[RAW_BITS-2:0], 1'b0};
            r_rem <= fits ? diff[3:0] : trial[3:0];
            r_quo <= {r_quo[RAW_BITS-2:0], fits};
        end
    end

    // acceleration above 63, clamp at 127
    always_comb begin
        if (r_quo >= RAW_BITS'(86)) begin
            q8 = 8'd127;
        end else if (r_quo >= RAW_BITS'(64)) begin
            q8 = r_quo[7:0] + {1'b0, r_quo[7:1]};
        end else begin
            q8 = r_quo[7:0];
        end
        mag8        = r_neg ? (~q8 + 8'd1) : q8;
        o_res.done  = r_done;
        o_res.delta = mag8;
    end

endmodule

/* rtl/cmnp_merge.sv */
module cmnp_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cmnp_pkg::t_lane_res i_x,
    input  cmnp_pkg::t_lane_res i_y,
    input  logic                i_wide,
    output cmnp_pkg::t_move     o_move
);
    import cmnp_pkg::*;

    logic r_take_x, n_take_x;
    logic unit_x, unit_y, diag;

    always_comb begin
        unit_x      = (i_x.delta == 8'h01) || (i_x.delta == 8'hFF);
        unit_y      = (i_y.delta == 8'h01) || (i_y.delta == 8'hFF);
        diag        = i_wide && unit_x && unit_y;
        o_move.valid = i_x.done && i_y.done;
        o_move.dx    = i_x.delta;
        o_move.dy    = i_y.delta;
        n_take_x     = r_take_x;
        if (o_move.valid && diag) begin
            if (r_take_x) begin
                o_move.dy = '0;
                n_take_x  = 1'b0;
            end else begin
                o_move.dx = '0;
                n_take_x  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take_x <= 1'b1;
        end else begin
            r_take_x <= n_take_x;
        end
    end

endmodule

/* verif/tb_console_mouse_nibble_port_top.sv */
module tb_console_mouse_nibble_port_top;
    import cmnp_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int RX_HOLD     = 400;
    localparam int TAIL        = 20;

    typedef struct {
        t_op                        op;
        logic signed [RAW_BITS-1:0] raw_dx;
        logic signed [RAW_BITS-1:0] raw_dy;
        logic                       wide_display;
        logic [3:0]                 host_buttons;
        logic [3:0]                 pad_buttons;
        logic                       overclocked;
    } t_mouse_req;

    typedef struct {
        t_op        op;
        logic [3:0] data;
    } t_port_answer;

    class mouse_port_checker;
        logic [3:0]         mag;
        bit                 conn, swap_sr, swap_12;
        logic [TICK_W-1:0]  thresh;
        logic [WHEEL_W-1:0] hold;

        logic [2:0]         read_idx;
        logic [7:0]         delta_x, delta_y;
        bit                 take_x;
        logic [3:0]         btn;
        logic [TICK_W-1:0]  ticks;
        logic [WHEEL_W-1:0] wheel;

        t_port_answer answers_due[$];
        int errors, checked, frames, resets_taken, wheel_releases;

        function new();
            mag = MAG_RESET;
            conn = 0;
            swap_sr = 0;
            swap_12 = 0;
            thresh = THRESHOLD_RESET;
            hold = WHEEL_RESET;
            read_idx = '0;
            delta_x = '0;
            delta_y = '0;
            take_x = 1;
            btn = '0;
            ticks = '0;
            wheel = '0;
        endfunction

        function void set_reg(t_reg idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_MAG:       mag = v[3:0];
                REG_CONNECTED: conn = v[0];
                REG_SWAP_SR:   swap_sr = v[0];
                REG_SWAP_12:   swap_12 = v[0];
                REG_THRESHOLD: thresh = v[TICK_W-1:0];
                REG_WHEEL:     hold = v[WHEEL_W-1:0];
                default: ;
            endcase
        endfunction

        // divide rounding away from zero, then accelerate and clamp
        function int scaled(int d, int m);
            int a, q;
            a = (d < 0) ? -d : d;
            q = (a + m - 1) / m;
            if (q >= 64) begin
                q = q + q / 2;
                if (q > 127) q = 127;
            end
            return (d < 0) ? -q : q;
        endfunction

        function logic [3:0] port_answer(t_mouse_req r);
            logic [3:0] data, b;
            int m, dx, dy;
            data = '0;
            case (r.op)
                OP_TICK: begin
                    if (ticks != TICK_MAX) ticks++;
                    if (wheel != 0 && !r.overclocked) begin
                        wheel--;
                        if (wheel == 0) begin
                            btn[3:2] = 2'b00;
                            wheel_releases++;
                        end
                    end
                end
                OP_FRAME: if (conn) begin
                    m = (mag == 0) ? 1 : int'(mag);
                    dx = scaled(int'(r.raw_dx), m);
                    dy = scaled(int'(r.raw_dy), m);
                    if (r.wide_display && (dx == 1 || dx == -1) && (dy == 1 || dy == -1)) begin
                        if (take_x) begin
                            dy = 0;
                            take_x = 0;
                        end else begin
                            dx = 0;
                            take_x = 1;
                        end
                    end
                    delta_x = dx[7:0];
                    delta_y = dy[7:0];
                    frames++;
                end
                OP_RESET: if (ticks >= thresh) begin
                    read_idx = '0;
                    ticks = '0;
                    resets_taken++;
                end
                OP_READ_D: begin
                    case (read_idx)
                        3'd0: begin data = delta_x[7:4]; read_idx = 3'd1; end
                        3'd1: begin data = delta_x[3:0]; read_idx = 3'd2; end
                        3'd2: begin data = delta_y[7:4]; read_idx = 3'd3; end
                        3'd3: begin data = delta_y[3:0]; read_idx = 3'd4; end
                        default: begin
                            delta_x = '0;
                            delta_y = '0;
                            read_idx = 3'd4;
                        end
                    endcase
                end
                OP_READ_B: begin
                    b = btn;
                    if (b[3:2] == 2'b11) b[3:2] = 2'b00;
                    b = b | r.pad_buttons;
                    if (swap_sr) b = {b[2], b[3], b[1:0]};
                    if (swap_12) b = {b[3:2], b[0], b[1]};
                    data = ~b;
                end
                OP_SET_B: btn = r.host_buttons;
                OP_WHEEL: wheel = hold;
                default: ;
            endcase
            return data;
        endfunction

        function void note_request(t_mouse_req r);
            t_port_answer a;
            a.op = r.op;
            a.data = port_answer(r);
            answers_due.push_back(a);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("ERROR: %s", msg);
        endtask

        task check_result(logic [3:0] got);
            t_port_answer want;
            if (answers_due.size() == 0) begin
                report($sformatf("result %h with no transaction outstanding", got));
                return;
            end
            want = answers_due.pop_front();
            checked++;
            if (got !== want.data)
                report($sformatf("%s result %0d: data %h, expected %h",
                                 want.op.name(), checked, got, want.data));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    cmnp_in_if  req_if();
    cmnp_out_if res_if();

    console_mouse_nibble_port_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (req_if),
        .o_result   (res_if)
    );

    mouse_port_checker sb = new();
    t_mouse_req seen;
    int  sent = 0;
    int  cycles = 0;
    int  rx_hold_req = 0;
    int  rx_hold_done = 0;
    bit  tx_steady = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
            if (req_if.valid && req_if.ready) begin
                seen.op = t_op'(req_if.op);
                seen.raw_dx = req_if.raw_dx;
                seen.raw_dy = req_if.raw_dy;
                seen.wide_display = req_if.wide_display;
                seen.host_buttons = req_if.host_buttons;
                seen.pad_buttons = req_if.pad_buttons;
                seen.overclocked = req_if.overclocked;
                sb.note_request(seen);
            end
        end
    end

    initial begin : receiver
        int  span;
        bit  stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req != rx_hold_done) begin
                rx_hold_done++;
                res_if.ready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end else begin
                stall = ($urandom_range(0, 99) < 30);
                if (stall)
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
                else
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                       : $urandom_range(1, 12);
                res_if.ready <= !stall;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [RAW_BITS-1:0] pick_raw(int m, bit unit_move);
        int v;
        if (unit_move) v = $urandom_range(1, m);
        else case ($urandom_range(0, 4))
            0: return RAW_BITS'($urandom);
            1: v = $urandom_range(0, 2 * m);
            2: v = $urandom_range(62 * m, 66 * m);
            3: v = $urandom_range(84 * m, 86 * m);
            default: v = ($urandom_range(0, 1) != 0) ? 2 ** (RAW_BITS - 1) : 2047;
        endcase
        if ($urandom_range(0, 1) != 0) v = -v;
        if (v > 2 ** (RAW_BITS - 1) - 1) v = 2 ** (RAW_BITS - 1) - 1;
        if (v < -(2 ** (RAW_BITS - 1))) v = -(2 ** (RAW_BITS - 1));
        return v[RAW_BITS-1:0];
    endfunction

    function automatic t_mouse_req make_req(t_op op);
        t_mouse_req r;
        int  m;
        bit  unit_move;
        m = (sb.mag == 0) ? 1 : int'(sb.mag);
        unit_move = (op == OP_FRAME) && ($urandom_range(0, 3) == 0);
        r.op = op;
        r.raw_dx = pick_raw(m, unit_move);
        r.raw_dy = pick_raw(m, unit_move);
        r.wide_display = unit_move ? 1'b1 : 1'($urandom_range(0, 1));
        r.host_buttons = 4'($urandom);
        r.pad_buttons = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b0000;
        r.overclocked = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    task automatic send(t_mouse_req r);
        req_if.valid <= 1'b1;
        req_if.op <= r.op;
        req_if.raw_dx <= r.raw_dx;
        req_if.raw_dy <= r.raw_dy;
        req_if.wide_display <= r.wide_display;
        req_if.host_buttons <= r.host_buttons;
        req_if.pad_buttons <= r.pad_buttons;
        req_if.overclocked <= r.overclocked;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_gap(t_mouse_req r);
        int n;
        send(r);
        n = tx_gap();
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic directed();
        t_mouse_req r;
        // disconnected mouse ignores frame updates
        r = make_req(OP_FRAME);
        r.raw_dx = RAW_BITS'(100);
        r.raw_dy = RAW_BITS'(-100);
        send_gap(r);
        send_gap(make_req(OP_READ_D));
        send_gap(make_req(OP_UNUSED));
        r = make_req(OP_TICK);
        r.overclocked = 1'b1;
        send_gap(r);
        drain();
        write_reg(REG_MAG, CFG_W'(0));
        write_reg(REG_CONNECTED, CFG_W'(1));
        write_reg(REG_SWAP_SR, CFG_W'(1));
        write_reg(REG_SWAP_12, CFG_W'(1));
        write_reg(REG_THRESHOLD, CFG_W'(1));
        write_reg(REG_WHEEL, CFG_W'(2));
        i_cfg_we <= 1'b0;
        r = make_req(OP_FRAME);
        r.raw_dx = RAW_BITS'(2047);
        r.raw_dy = RAW_BITS'(-2048);
        send_gap(r);
        repeat (5) send_gap(make_req(OP_READ_D));
        send_gap(make_req(OP_TICK));
        send_gap(make_req(OP_RESET));
        // unit diagonals alternate axes in wide mode
        r = make_req(OP_FRAME);
        r.raw_dx = RAW_BITS'(1);
        r.raw_dy = RAW_BITS'(-1);
        r.wide_display = 1'b1;
        send_gap(r);
        r.raw_dx = RAW_BITS'(-1);
        r.raw_dy = RAW_BITS'(1);
        send_gap(r);
        repeat (2) send_gap(make_req(OP_READ_D));
        r = make_req(OP_SET_B);
        r.host_buttons = 4'hF;
        send_gap(r);
        r = make_req(OP_READ_B);
        r.pad_buttons = 4'h0;
        send_gap(r);
        r = make_req(OP_SET_B);
        r.host_buttons = 4'h5;
        send_gap(r);
        send_gap(make_req(OP_WHEEL));
        r = make_req(OP_TICK);
        r.overclocked = 1'b0;
        send_gap(r);
        r.overclocked = 1'b1;
        send_gap(r);
        r.overclocked = 1'b0;
        send_gap(r);
        r = make_req(OP_READ_B);
        r.pad_buttons = 4'hA;
        send_gap(r);
    endtask

    task automatic configure(int p);
        logic [3:0] m;
        case (p)
            0: m = 4'd1;
            1: m = 4'd8;
            2: m = 4'd15;
            3: m = 4'd0;
            default: m = 4'($urandom_range(0, 15));
        endcase
        write_reg(REG_MAG, CFG_W'(m));
        write_reg(REG_CONNECTED, CFG_W'((p == 4) ? 0 : 1));
        write_reg(REG_SWAP_SR, CFG_W'(p % 2));
        write_reg(REG_SWAP_12, CFG_W'((p / 2) % 2));
        write_reg(REG_THRESHOLD,
                  CFG_W'((p == 5) ? int'(TICK_MAX) : (p == 6) ? 1 : $urandom_range(1, 40)));
        write_reg(REG_WHEEL,
                  CFG_W'((p == 5) ? int'({WHEEL_W{1'b1}}) : (p == 6) ? 1
                                                            : $urandom_range(1, 30)));
        i_cfg_we <= 1'b0;
        tx_steady = (p == 3);
    endtask

    // host polling: tick for a random span around the reset delay, restart, latch a move, read it back
    task automatic poll_sequence();
        int lim;
        lim = (sb.thresh > 40) ? 40 : int'(sb.thresh) + 3;
        repeat ($urandom_range(0, lim)) send_gap(make_req(OP_TICK));
        send_gap(make_req(OP_RESET));
        send_gap(make_req(OP_FRAME));
        repeat ($urandom_range(4, 6)) send_gap(make_req(OP_READ_D));
        if ($urandom_range(0, 1) != 0) send_gap(make_req(OP_READ_B));
    endtask

    task automatic button_sequence();
        int lim;
        lim = (sb.hold > 30) ? 30 : int'(sb.hold) + 2;
        send_gap(make_req(OP_SET_B));
        if ($urandom_range(0, 1) != 0) send_gap(make_req(OP_WHEEL));
        repeat ($urandom_range(0, lim))
            send_gap(make_req(($urandom_range(0, 3) == 0) ? OP_READ_B : OP_TICK));
        send_gap(make_req(OP_READ_B));
    endtask

    task automatic run_phase();
        int start;
        start = sent;
        while (sent - start < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: poll_sequence();
                5, 6: button_sequence();
                default: send_gap(make_req(t_op'($urandom_range(0, 7))));
            endcase
        end
    endtask

    initial begin : stimulus
        int p;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_MAG;
        i_cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.op <= OP_TICK;
        req_if.raw_dx <= '0;
        req_if.raw_dy <= '0;
        req_if.wide_display <= 1'b0;
        req_if.host_buttons <= '0;
        req_if.pad_buttons <= '0;
        req_if.overclocked <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed();
        for (p = 0; p < PHASES; p++) begin
            drain();
            configure(p);
            // long output back-pressure while requests keep coming
            if (p == 1) rx_hold_req++;
            run_phase();
        end
        drain();
        repeat (TAIL) @(posedge i_clk);
        if (sb.answers_due.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.answers_due.size()));
        $display("sent %0d transactions over %0d register settings, %0d results checked",
                 sent, PHASES + 2, sb.checked);
        $display("%0d frame updates latched, %0d restarts taken, %0d wheel releases",
                 sb.frames, sb.resets_taken, sb.wheel_releases);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cmnp_pkg.sv
rtl/cmnp_in_if.sv
rtl/cmnp_out_if.sv
rtl/cmnp_lane.sv
rtl/cmnp_merge.sv
rtl/console_mouse_nibble_port_top.sv
verif/tb_console_mouse_nibble_port_top.sv
